FILE: sv/x86enc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// x86enc_pkg: shared types and constants of the x86-64 instruction encoder
// no dependencies; used by the front end, the queue and the back end

package x86enc_pkg;

    localparam int MAX_BYTES = 10;
    localparam int LEN_W     = 4;
    localparam int IN_W      = 120;

    // request operation codes
    typedef enum logic [4:0] {
        OP_MOVIMM64 = 5'd0,
        OP_MOV      = 5'd1,
        OP_ADD      = 5'd2,
        OP_AND      = 5'd3,
        OP_ADDIMM   = 5'd4,
        OP_SUB      = 5'd5,
        OP_IMUL     = 5'd6,
        OP_INC      = 5'd7,
        OP_DEC      = 5'd8,
        OP_PUSH     = 5'd9,
        OP_POP      = 5'd10,
        OP_CALL     = 5'd11,
        OP_LOAD     = 5'd12,
        OP_STORE    = 5'd13,
        OP_CMPIMM   = 5'd14,
        OP_CMP      = 5'd15,
        OP_JMP      = 5'd16,
        OP_JE       = 5'd17,
        OP_JNE      = 5'd18,
        OP_JAE      = 5'd19,
        OP_JGE      = 5'd20,
        OP_JL       = 5'd21,
        OP_RET      = 5'd22
    } opc_t;

    // machine code constants
    localparam logic [7:0] REX_W     = 8'h48;
    localparam logic [7:0] REX_B     = 8'h41;
    localparam logic [7:0] OPB_MOVRI = 8'hB8;
    localparam logic [7:0] OPB_MOV   = 8'h89;
    localparam logic [7:0] OPB_LOAD  = 8'h8B;
    localparam logic [7:0] OPB_ADD   = 8'h01;
    localparam logic [7:0] OPB_AND   = 8'h21;
    localparam logic [7:0] OPB_SUB   = 8'h29;
    localparam logic [7:0] OPB_CMP   = 8'h39;
    localparam logic [7:0] OPB_GRP1  = 8'h81;
    localparam logic [7:0] OPB_GRP5  = 8'hFF;
    localparam logic [7:0] OPB_ESC   = 8'h0F;
    localparam logic [7:0] OPB_IMUL  = 8'hAF;
    localparam logic [7:0] OPB_SIB   = 8'h24;
    localparam logic [7:0] OPB_JMP   = 8'hE9;
    localparam logic [7:0] OPB_JE    = 8'h84;
    localparam logic [7:0] OPB_JNE   = 8'h85;
    localparam logic [7:0] OPB_JAE   = 8'h83;
    localparam logic [7:0] OPB_JGE   = 8'h8D;
    localparam logic [7:0] OPB_JL    = 8'h8C;
    localparam logic [7:0] OPB_RET   = 8'hC3;
    localparam logic [7:0] OPB_PUSH  = 8'h50;
    localparam logic [7:0] OPB_POP   = 8'h58;
    localparam logic [7:0] OPB_CALLR = 8'hD0;

    // fully encoded instruction, byte 0 goes out first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
        logic                      err;
    } plan_t;

endpackage

`default_nettype wire

FILE: sv/x86enc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// x86enc_front: accepts requests, decodes them into a full byte plan, one register stage
// depends on x86enc_pkg

module x86enc_front
    import x86enc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [IN_W-1:0] s_axis_tdata,
    output logic                 plan_valid,
    input  wire logic            plan_ready,
    output plan_t                plan
);

    function automatic logic [7:0] rex_f(input logic reg_hi, input logic rm_hi);
        rex_f = REX_W | {5'b0, reg_hi, 1'b0, rm_hi};
    endfunction

    function automatic logic [7:0] modrm_f(input logic [1:0] md, input logic [2:0] rg,
                                           input logic [2:0] rm);
        modrm_f = {md, rg, rm};
    endfunction

    opc_t        opc;
    logic [3:0]  ra;
    logic [3:0]  rb;
    logic [3:0]  bs;
    logic [63:0] imm;
    logic [31:0] disp;
    logic [3:0]  mreg;
    logic [7:0]  op_b;
    plan_t       plan_d;

    logic  valid_reg;
    logic  valid_next;
    plan_t plan_reg;

    assign opc  = opc_t'(s_axis_tdata[4:0]);
    assign ra   = s_axis_tdata[8:5];
    assign rb   = s_axis_tdata[12:9];
    assign bs   = s_axis_tdata[16:13];
    assign imm  = s_axis_tdata[80:17];
    assign disp = s_axis_tdata[112:81];

    // operation byte of two-register, memory and branch forms
    always_comb
    begin
        unique case (opc)
            OP_MOV:   op_b = OPB_MOV;
            OP_ADD:   op_b = OPB_ADD;
            OP_AND:   op_b = OPB_AND;
            OP_SUB:   op_b = OPB_SUB;
            OP_CMP:   op_b = OPB_CMP;
            OP_LOAD:  op_b = OPB_LOAD;
            OP_STORE: op_b = OPB_MOV;
            OP_JE:    op_b = OPB_JE;
            OP_JNE:   op_b = OPB_JNE;
            OP_JAE:   op_b = OPB_JAE;
            OP_JGE:   op_b = OPB_JGE;
            OP_JL:    op_b = OPB_JL;
            default:  op_b = OPB_RET;
        endcase
    end

    assign mreg = (opc == OP_LOAD) ? ra : rb;

    always_comb
    begin
        plan_d     = '0;
        plan_d.len = LEN_W'(1);
        unique case (opc)
            OP_MOVIMM64:
            begin
                plan_d.bytes[0]   = rex_f(1'b0, ra[3]);
                plan_d.bytes[1]   = OPB_MOVRI + {5'b0, ra[2:0]};
                plan_d.bytes[9:2] = imm;
                plan_d.len        = LEN_W'(10);
            end
            OP_MOV, OP_ADD, OP_AND, OP_SUB, OP_CMP:
            begin
                plan_d.bytes[0] = rex_f(rb[3], ra[3]);
                plan_d.bytes[1] = op_b;
                plan_d.bytes[2] = modrm_f(2'b11, rb[2:0], ra[2:0]);
                plan_d.len      = LEN_W'(3);
            end
            OP_ADDIMM:
            begin
                plan_d.bytes[0] = rex_f(1'b0, ra[3]);
                plan_d.bytes[2] = modrm_f(2'b11, 3'd0, ra[2:0]);
                // add of one becomes inc
                if (imm[31:0] == 32'd1)
                begin
                    plan_d.bytes[1] = OPB_GRP5;
                    plan_d.len      = LEN_W'(3);
                end
                else
                begin
                    plan_d.bytes[1]   = OPB_GRP1;
                    plan_d.bytes[6:3] = imm[31:0];
                    plan_d.len        = LEN_W'(7);
                end
            end
            OP_CMPIMM:
            begin
                plan_d.bytes[0]   = rex_f(1'b0, ra[3]);
                plan_d.bytes[1]   = OPB_GRP1;
                plan_d.bytes[2]   = modrm_f(2'b11, 3'd7, ra[2:0]);
                plan_d.bytes[6:3] = imm[31:0];
                plan_d.len        = LEN_W'(7);
            end
            OP_IMUL:
            begin
                plan_d.bytes[0] = rex_f(ra[3], rb[3]);
                plan_d.bytes[1] = OPB_ESC;
                plan_d.bytes[2] = OPB_IMUL;
                plan_d.bytes[3] = modrm_f(2'b11, ra[2:0], rb[2:0]);
                plan_d.len      = LEN_W'(4);
            end
            OP_INC, OP_DEC:
            begin
                plan_d.bytes[0] = rex_f(1'b0, ra[3]);
                plan_d.bytes[1] = OPB_GRP5;
                plan_d.bytes[2] = modrm_f(2'b11, {2'b0, opc == OP_DEC}, ra[2:0]);
                plan_d.len      = LEN_W'(3);
            end
            OP_PUSH, OP_POP:
            begin
                if (ra[3])
                begin
                    plan_d.bytes[0] = REX_B;
                    plan_d.bytes[1] = ((opc == OP_PUSH) ? OPB_PUSH : OPB_POP)
                                      + {5'b0, ra[2:0]};
                    plan_d.len      = LEN_W'(2);
                end
                else
                begin
                    plan_d.bytes[0] = ((opc == OP_PUSH) ? OPB_PUSH : OPB_POP)
                                      + {5'b0, ra[2:0]};
                end
            end
            OP_CALL:
            begin
                // extended register has no plain encoding here
                if (ra[3])
                begin
                    plan_d.err = 1'b1;
                end
                else
                begin
                    plan_d.bytes[0] = OPB_GRP5;
                    plan_d.bytes[1] = OPB_CALLR + {5'b0, ra[2:0]};
                    plan_d.len      = LEN_W'(2);
                end
            end
            OP_LOAD, OP_STORE:
            begin
                plan_d.bytes[0] = rex_f(mreg[3], bs[3]);
                plan_d.bytes[1] = op_b;
                plan_d.bytes[2] = modrm_f(2'b10, mreg[2:0], bs[2:0]);
                // rsp or r12 base needs a sib byte
                if (bs[2:0] == 3'd4)
                begin
                    plan_d.bytes[3]   = OPB_SIB;
                    plan_d.bytes[7:4] = disp;
                    plan_d.len        = LEN_W'(8);
                end
                else
                begin
                    plan_d.bytes[6:3] = disp;
                    plan_d.len        = LEN_W'(7);
                end
            end
            OP_JMP:
            begin
                plan_d.bytes[0]   = OPB_JMP;
                plan_d.bytes[4:1] = disp;
                plan_d.len        = LEN_W'(5);
            end
            OP_JE, OP_JNE, OP_JAE, OP_JGE, OP_JL:
            begin
                plan_d.bytes[0]   = OPB_ESC;
                plan_d.bytes[1]   = op_b;
                plan_d.bytes[5:2] = disp;
                plan_d.len        = LEN_W'(6);
            end
            OP_RET:
            begin
                plan_d.bytes[0] = OPB_RET;
            end
            default:
            begin
                plan_d.err = 1'b1;
            end
        endcase
    end

    assign s_axis_tready = !valid_reg || plan_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (plan_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            plan_reg <= plan_d;
        end
    end

    assign plan_valid = valid_reg;
    assign plan       = plan_reg;

endmodule

`default_nettype wire

FILE: sv/x86enc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// x86enc_queue: short first-in first-out queue of decoded plans
// depends on x86enc_pkg

module x86enc_queue
    import x86enc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire plan_t push_plan,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output plan_t      pop_plan
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    plan_t         slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_plan   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_plan;
        end
    end

endmodule

`default_nettype wire

FILE: sv/x86enc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// x86enc_back: holds one decoded plan and sends its bytes one per cycle while m_axis_tready is high
// depends on x86enc_pkg

module x86enc_back
    import x86enc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  plan_valid,
    output logic       plan_ready,
    input  wire plan_t plan,
    output logic       m_axis_tvalid,
    input  wire logic  m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output logic       m_axis_tuser
);

    plan_t            cur_reg;
    logic             cur_valid_reg;
    logic             cur_valid_next;
    logic [LEN_W-1:0] idx_reg;
    logic [LEN_W-1:0] idx_next;
    logic             is_last;
    logic             load;

    assign is_last = (idx_reg == cur_reg.len - LEN_W'(1));
    // take the next plan when empty or when the last byte leaves
    assign load       = !cur_valid_reg || (m_axis_tready && is_last);
    assign plan_ready = load;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            cur_valid_next = plan_valid;
            idx_next       = '0;
        end
        else if (m_axis_tready)
        begin
            idx_next = idx_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && plan_valid)
        begin
            cur_reg <= plan;
        end
    end

    assign m_axis_tvalid = cur_valid_reg;
    assign m_axis_tdata  = cur_reg.bytes[idx_reg];
    assign m_axis_tlast  = is_last;
    assign m_axis_tuser  = cur_reg.err;

endmodule

`default_nettype wire

FILE: sv/x86_64_instruction_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// x86_64_instruction_encoder: turns one instruction request into its x86-64 code bytes
// path: an accepted item is registered in the front stage, then in a queue slot, then in
//   the output holder, from which its first byte is sent
// throughput: one byte per cycle while m_axis_tready is high; items have 1 to 10 bytes,
//   sent on the single byte lane; items follow with no gap while the next one is queued
// reset: rst_n clears the front stage, queue and output holder; no output after reset
// depends on x86enc_pkg, x86enc_front, x86enc_queue, x86enc_back

module x86_64_instruction_encoder
    import x86enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // request channel
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata: opcode[4:0], reg_a[8:5], reg_b[12:9], base_reg[16:13],
    //        immediate[80:17], displacement[112:81], zero fill[119:113]
    input  wire logic [119:0] s_axis_tdata,
    // code byte channel
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata: code_byte[7:0]
    output logic [7:0]        m_axis_tdata,
    // tlast: last_byte of the instruction
    output logic              m_axis_tlast,
    // tuser: error[0]
    output logic              m_axis_tuser
);

    // front end to queue
    logic  f_valid;
    logic  f_ready;
    plan_t f_plan;

    // queue to back end
    logic  q_valid;
    logic  q_ready;
    plan_t q_plan;

    // decode each request into a complete byte plan
    x86enc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .plan_valid    (f_valid),
        .plan_ready    (f_ready),
        .plan          (f_plan)
    );

    // decouples decoding from the byte-serial output
    x86enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_plan  (f_plan),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_plan   (q_plan)
    );

    // serialize the plan, one byte per accepted output item
    x86enc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .plan_valid    (q_valid),
        .plan_ready    (q_ready),
        .plan          (q_plan),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

FILE: sv/x86enc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// x86enc_checker: port-level checks of the encoder output stream
// bound to x86_64_instruction_encoder; no package dependency

module x86enc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       m_axis_tuser
);

    // an error item is a single zero byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
        else $error("error item not a single zero byte");

    // inside an instruction the next byte follows at once and carries no error
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && !m_axis_tuser)
        else $error("gap or error inside an instruction");

    // output empty right after reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // a stalled byte holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output byte changed");

endmodule

bind x86_64_instruction_encoder x86enc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
